// ===== rtl/core/script_token_lexer_top_macros.svh =====
// ----------------------------------------------------------------------------
// script token lexer assertion macros
// concurrent checks on the rising edge of i_clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_LEXER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_LEXER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every edge out of reset
`define STL_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define STL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`else

`define STL_ASSERT(label, expr, msg)
`define STL_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/stl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// shared token codes, widths and the command format between front and back
// ----------------------------------------------------------------------------
package stl_pkg;

    // default name buffer depth, and the fixed width of a name length
    localparam int MAX_NAME_LEN_DEF = 32;
    localparam int NAME_LEN_W       = 6;
    localparam int CMD_FIFO_DEPTH   = 2;

    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 5;
    localparam int CHAR_W  = 8;

    // token kinds
    localparam logic [KIND_W-1:0] TK_EOF      = 4'd0;
    localparam logic [KIND_W-1:0] TK_IF       = 4'd1;
    localparam logic [KIND_W-1:0] TK_SET      = 4'd2;
    localparam logic [KIND_W-1:0] TK_DEFINE   = 4'd3;
    localparam logic [KIND_W-1:0] TK_BRIGHTER = 4'd4;
    localparam logic [KIND_W-1:0] TK_MAG      = 4'd5;
    localparam logic [KIND_W-1:0] TK_INTEGER  = 4'd6;
    localparam logic [KIND_W-1:0] TK_DECIMAL  = 4'd7;
    localparam logic [KIND_W-1:0] TK_NAME     = 4'd8;
    localparam logic [KIND_W-1:0] TK_LPAREN   = 4'd9;
    localparam logic [KIND_W-1:0] TK_RPAREN   = 4'd10;
    localparam logic [KIND_W-1:0] TK_LBRACK   = 4'd11;
    localparam logic [KIND_W-1:0] TK_RBRACK   = 4'd12;
    localparam logic [KIND_W-1:0] TK_INVALID  = 4'd13;

    // at most one command per input transaction: an optional finished number or name,
    // then an optional single-result token
    typedef struct packed {
        logic                      head_valid;
        logic [KIND_W-1:0]         head_kind;
        logic signed [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]         frac;
        logic                      sat;
        logic [NAME_LEN_W-1:0]     name_len;
        logic                      tail_valid;
        logic [KIND_W-1:0]         tail_kind;
    } t_cmd;

    // back end status seen by the front end
    typedef struct packed {
        logic name_active;
        logic name_done;
    } t_back_stat;

endpackage

// ===== rtl/core/stl_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl channel interfaces
// valid/ready channels for characters in and tokens out
// ----------------------------------------------------------------------------
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface stl_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         token_kind;
    logic signed [31:0] number_value;
    logic [4:0]         fraction_digits;
    logic [7:0]         name_char;
    logic               saturated;
    logic               last;

    modport source (output valid, output token_kind, output number_value,
                    output fraction_digits, output name_char, output saturated,
                    output last, input ready);
    modport sink   (input valid, input token_kind, input number_value,
                    input fraction_digits, input name_char, input saturated,
                    input last, output ready);
endinterface

// ===== rtl/core/stl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module stl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stl_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_cmd_fifo
// short command queue between the lexer front end and the token back end
// ----------------------------------------------------------------------------
module stl_cmd_fifo #(
    parameter int DEPTH = stl_pkg::CMD_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stl_pkg::t_cmd i_data,
    input  logic          i_pop,
    output stl_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    stl_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== rtl/core/stl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front
// lexer front end: takes characters, tracks the lex mode, builds numbers,
// writes name characters and queues at most one command per transaction
// ----------------------------------------------------------------------------
module stl_front #(
    parameter int MAX_NAME_LEN = stl_pkg::MAX_NAME_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    stl_in_if.sink                          i_in,
    input  logic                            i_fifo_full,
    input  stl_pkg::t_back_stat             i_stat,
    output logic                            o_push,
    output stl_pkg::t_cmd                   o_cmd,
    output logic                            o_we,
    output logic [$clog2(MAX_NAME_LEN)-1:0] o_waddr,
    output logic [stl_pkg::CHAR_W-1:0]      o_wdata
);

    localparam int AW   = $clog2(MAX_NAME_LEN);
    localparam int LW   = stl_pkg::NAME_LEN_W;
    localparam int KW_N = 5;

    typedef enum logic [3:0] {
        LM_IDLE    = 4'b0001,
        LM_COMMENT = 4'b0010,
        LM_NUMBER  = 4'b0100,
        LM_NAME    = 4'b1000
    } t_lex_mode;

    // keyword spelling, upper case, first character at position zero
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [63:0] w;
        int          l;
        int          idx;
        case (k)
            3'd0:    begin w = 64'("IF");       l = 2; end
            3'd1:    begin w = 64'("SET");      l = 3; end
            3'd2:    begin w = 64'("DEFINE");   l = 6; end
            3'd3:    begin w = 64'("BRIGHTER"); l = 8; end
            3'd4:    begin w = 64'("MAG");      l = 3; end
            default: begin w = '0;              l = 1; end
        endcase
        idx = l - 1 - int'(p);
        if (idx < 0) begin
            return 8'h00;
        end
        return w[idx*8 +: 8];
    endfunction

    function automatic logic [LW-1:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0:    return LW'(2);
            3'd1:    return LW'(3);
            3'd2:    return LW'(6);
            3'd3:    return LW'(8);
            3'd4:    return LW'(3);
            default: return '0;
        endcase
    endfunction

    function automatic logic [stl_pkg::KIND_W-1:0] kw_token(input logic [2:0] k);
        case (k)
            3'd0:    return stl_pkg::TK_IF;
            3'd1:    return stl_pkg::TK_SET;
            3'd2:    return stl_pkg::TK_DEFINE;
            3'd3:    return stl_pkg::TK_BRIGHTER;
            3'd4:    return stl_pkg::TK_MAG;
            default: return stl_pkg::TK_NAME;
        endcase
    endfunction

    t_lex_mode        r_mode, n_mode;
    logic             r_neg, n_neg;
    logic [31:0]      r_mant, n_mant;
    logic [1:0]       r_dot, n_dot;
    logic [4:0]       r_frac, n_frac;
    logic [LW-1:0]    r_len, n_len;
    logic             r_ovf, n_ovf;
    logic [KW_N-1:0]  r_kw_ok, n_kw_ok;
    logic             r_name_busy, n_name_busy;

    logic             accept;
    logic [7:0]       c;
    logic [7:0]       c_up;
    logic             is_space, is_digit, is_alpha, is_name;
    logic [35:0]      mant_next;
    logic [35:0]      mant_limit;
    logic [KW_N-1:0]  kw_cont, kw_start;
    logic             do_idle;
    stl_pkg::t_cmd    cmd;

    // character classes
    assign c        = i_in.char_code;
    assign c_up     = (c inside {[8'h61:8'h7a]}) ? c - 8'h20 : c;
    assign is_space = c inside {8'h20, [8'h09:8'h0d]};
    assign is_digit = c inside {[8'h30:8'h39]};
    assign is_alpha = c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    assign is_name  = is_alpha || is_digit || (c inside {8'h2b, 8'h5f, 8'h2d});

    assign i_in.ready = !i_fifo_full && !r_name_busy;
    assign accept     = i_in.valid && i_in.ready;

    // next mantissa: times ten by shift-add, plus the digit
    assign mant_next  = {1'b0, r_mant, 3'b000} + {3'b000, r_mant, 1'b0}
                        + {32'd0, c[3:0]};
    assign mant_limit = r_neg ? 36'h0_8000_0000 : 36'h0_7fff_ffff;

    // incremental keyword match per name character
    always_comb begin
        for (int k = 0; k < KW_N; k++) begin
            kw_cont[k]  = r_kw_ok[k] && (r_len < kw_len(3'(k)))
                          && (c_up == kw_char(3'(k), r_len[2:0]));
            kw_start[k] = (c_up == kw_char(3'(k), 3'd0));
        end
    end

    // lexer step
    always_comb begin
        n_mode      = r_mode;
        n_neg       = r_neg;
        n_mant      = r_mant;
        n_dot       = r_dot;
        n_frac      = r_frac;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_kw_ok     = r_kw_ok;
        n_name_busy = r_name_busy;
        o_we        = 1'b0;
        o_waddr     = r_len[AW-1:0];
        o_wdata     = c;
        do_idle     = 1'b0;
        cmd         = '0;

        if (accept) begin
            // finished number or name goes at the head of the command
            if ((i_in.kind && r_mode == LM_NUMBER)
                || (!i_in.kind && r_mode == LM_NUMBER && !(is_digit || c == 8'h2e))) begin
                cmd.head_valid = 1'b1;
                cmd.head_kind  = (r_dot != 2'd0) ? stl_pkg::TK_DECIMAL
                                                 : stl_pkg::TK_INTEGER;
                cmd.value      = $signed(r_neg ? (~r_mant + 32'd1) : r_mant);
                cmd.frac       = (r_dot != 2'd0) ? r_frac : 5'd0;
                cmd.sat        = r_ovf;
            end
            if ((i_in.kind && r_mode == LM_NAME)
                || (!i_in.kind && r_mode == LM_NAME && !is_name)) begin
                cmd.head_valid = 1'b1;
                cmd.head_kind  = stl_pkg::TK_NAME;
                cmd.name_len   = r_len;
                cmd.sat        = r_ovf;
                for (int k = KW_N - 1; k >= 0; k--) begin
                    if (r_kw_ok[k] && !r_ovf && r_len == kw_len(3'(k))) begin
                        cmd.head_kind = kw_token(3'(k));
                        cmd.sat       = 1'b0;
                    end
                end
            end

            if (i_in.kind) begin
                // end of input
                n_mode         = LM_IDLE;
                cmd.tail_valid = 1'b1;
                cmd.tail_kind  = stl_pkg::TK_EOF;
            end else begin
                case (r_mode)
                    LM_COMMENT: begin
                        if (c == 8'h0a) begin
                            n_mode = LM_IDLE;
                        end
                    end
                    LM_NUMBER: begin
                        if (c == 8'h2e) begin
                            if (r_dot != 2'd2) begin
                                n_dot = r_dot + 2'd1;
                            end
                        end else if (is_digit) begin
                            if (r_dot == 2'd0) begin
                                if (mant_next > mant_limit) begin
                                    n_mant = mant_limit[31:0];
                                    n_ovf  = 1'b1;
                                end else begin
                                    n_mant = mant_next[31:0];
                                end
                            end else if (r_dot == 2'd1) begin
                                if (mant_next > mant_limit || r_frac == 5'd31) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_mant = mant_next[31:0];
                                    n_frac = r_frac + 5'd1;
                                end
                            end
                        end else begin
                            do_idle = 1'b1;
                        end
                    end
                    LM_NAME: begin
                        if (is_name) begin
                            if (r_len < LW'(MAX_NAME_LEN)) begin
                                o_we    = 1'b1;
                                n_len   = r_len + LW'(1);
                                n_kw_ok = kw_cont;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            do_idle = 1'b1;
                        end
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase
            end

            // character seen between tokens
            if (do_idle) begin
                n_mode = LM_IDLE;
                if (is_space) begin
                    n_mode = LM_IDLE;
                end else if (c == 8'h23) begin
                    n_mode = LM_COMMENT;
                end else if (is_digit || (c inside {8'h2d, 8'h2b, 8'h2e})) begin
                    n_mode = LM_NUMBER;
                    n_neg  = (c == 8'h2d);
                    n_mant = is_digit ? {28'd0, c[3:0]} : 32'd0;
                    n_dot  = (c == 8'h2e) ? 2'd1 : 2'd0;
                    n_frac = 5'd0;
                    n_ovf  = 1'b0;
                end else if (is_alpha) begin
                    n_mode  = LM_NAME;
                    n_len   = LW'(1);
                    n_ovf   = 1'b0;
                    n_kw_ok = kw_start;
                    o_we    = 1'b1;
                    o_waddr = '0;
                end else begin
                    cmd.tail_valid = 1'b1;
                    case (c)
                        8'h28:   cmd.tail_kind = stl_pkg::TK_LPAREN;
                        8'h29:   cmd.tail_kind = stl_pkg::TK_RPAREN;
                        8'h5b:   cmd.tail_kind = stl_pkg::TK_LBRACK;
                        8'h5d:   cmd.tail_kind = stl_pkg::TK_RBRACK;
                        default: cmd.tail_kind = stl_pkg::TK_INVALID;
                    endcase
                end
            end
        end

        // name buffer is held until the back end has read the run out
        if (accept && cmd.head_valid && cmd.head_kind == stl_pkg::TK_NAME) begin
            n_name_busy = 1'b1;
        end else if (i_stat.name_done) begin
            n_name_busy = 1'b0;
        end
    end

    assign o_push = cmd.head_valid || cmd.tail_valid;
    assign o_cmd  = cmd;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= LM_IDLE;
            r_name_busy <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_name_busy <= n_name_busy;
        end
    end

    // token build registers
    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_mant  <= n_mant;
        r_dot   <= n_dot;
        r_frac  <= n_frac;
        r_len   <= n_len;
        r_ovf   <= n_ovf;
        r_kw_ok <= n_kw_ok;
    end

endmodule

// ===== rtl/core/stl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back
// token back end: pops commands, reads name runs out of the name buffer and
// drives the registered result channel
// ----------------------------------------------------------------------------
module stl_back #(
    parameter int MAX_NAME_LEN = stl_pkg::MAX_NAME_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  stl_pkg::t_cmd                   i_head,
    output logic                            o_pop,
    output logic                            o_re,
    output logic [$clog2(MAX_NAME_LEN)-1:0] o_raddr,
    input  logic [stl_pkg::CHAR_W-1:0]      i_rdata,
    output stl_pkg::t_back_stat             o_stat,
    stl_out_if.source                       o_out
);

    localparam int AW = $clog2(MAX_NAME_LEN);
    localparam int LW = stl_pkg::NAME_LEN_W;

    typedef enum logic [4:0] {
        BS_IDLE    = 5'b00001,
        BS_FLUSH   = 5'b00010,
        BS_NAME_RD = 5'b00100,
        BS_NAME_WR = 5'b01000,
        BS_TAIL    = 5'b10000
    } t_back_state;

    t_back_state                   r_state, n_state;
    stl_pkg::t_cmd                 r_cmd, n_cmd;
    logic [LW-1:0]                 r_idx, n_idx;
    logic                          r_out_valid, n_out_valid;
    logic [stl_pkg::KIND_W-1:0]    r_kind, n_kind;
    logic signed [31:0]            r_value, n_value;
    logic [4:0]                    r_frac, n_frac;
    logic [7:0]                    r_char, n_char;
    logic                          r_sat, n_sat;
    logic                          r_last, n_last;

    logic                          slot_free;
    logic                          load;
    logic                          name_last;

    assign slot_free = !r_out_valid || o_out.ready;
    assign name_last = ((r_idx + LW'(1)) == r_cmd.name_len);
    assign o_raddr   = r_idx[AW-1:0];

    // command sequencer
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_kind  = r_kind;
        n_value = r_value;
        n_frac  = r_frac;
        n_char  = r_char;
        n_sat   = r_sat;
        n_last  = r_last;
        load    = 1'b0;
        o_pop   = 1'b0;
        o_re    = 1'b0;
        o_stat  = '0;

        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    n_idx = '0;
                    if (!i_head.head_valid) begin
                        n_state = BS_TAIL;
                    end else if (i_head.head_kind == stl_pkg::TK_NAME) begin
                        n_state = BS_NAME_RD;
                    end else begin
                        n_state = BS_FLUSH;
                    end
                end
            end
            BS_FLUSH: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_kind  = r_cmd.head_kind;
                    n_value = r_cmd.value;
                    n_frac  = r_cmd.frac;
                    n_char  = 8'h00;
                    n_sat   = r_cmd.sat;
                    n_last  = 1'b1;
                    n_state = r_cmd.tail_valid ? BS_TAIL : BS_IDLE;
                end
            end
            BS_NAME_RD: begin
                o_re    = 1'b1;
                n_state = BS_NAME_WR;
            end
            BS_NAME_WR: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_kind  = stl_pkg::TK_NAME;
                    n_value = '0;
                    n_frac  = '0;
                    n_char  = i_rdata;
                    n_sat   = r_cmd.sat;
                    n_last  = name_last;
                    if (name_last) begin
                        o_stat.name_done = 1'b1;
                        n_state = r_cmd.tail_valid ? BS_TAIL : BS_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = BS_NAME_RD;
                    end
                end
            end
            BS_TAIL: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_kind  = r_cmd.tail_kind;
                    n_value = '0;
                    n_frac  = '0;
                    n_char  = 8'h00;
                    n_sat   = 1'b0;
                    n_last  = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        o_stat.name_active = (r_state == BS_NAME_RD) || (r_state == BS_NAME_WR);
    end

    // output slot valid
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_value <= n_value;
        r_frac  <= n_frac;
        r_char  <= n_char;
        r_sat   <= n_sat;
        r_last  <= n_last;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.token_kind      = r_kind;
    assign o_out.number_value    = r_value;
    assign o_out.fraction_digits = r_frac;
    assign o_out.name_char       = r_char;
    assign o_out.saturated       = r_sat;
    assign o_out.last            = r_last;

endmodule

// ===== rtl/core/script_token_lexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_top
// streaming tokenizer for a small script language, one character in per
// transaction, tokens out as results
// ----------------------------------------------------------------------------
// The front end takes one character or end-of-input marker per cycle while the
// two-entry command queue has room and no name run is being read out of the
// name buffer. Every transaction that completes tokens queues one command; the
// back end pops it from its idle state, then sends each single-result token
// from the output register and each name character through a registered read
// of the name buffer ram, then the output register, whenever the output slot
// is free. A single-result token that follows a name is sent after the name's
// last character. From the transaction that ends a plain name until its last
// character has been read out, input is held off. A result waits in the output
// register without stopping the front end until the command queue fills. The
// name buffer powers up with unknown contents and needs no clearing pass: only
// characters of the current name are read.
// ----------------------------------------------------------------------------
`include "script_token_lexer_top_macros.svh"

module script_token_lexer_top #(
    parameter int MAX_NAME_LEN = stl_pkg::MAX_NAME_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stl_in_if.sink    i_in,
    stl_out_if.source o_out
);

    localparam int AW = $clog2(MAX_NAME_LEN);

    logic                         push;
    logic                         pop;
    logic                         fifo_full;
    logic                         fifo_empty;
    stl_pkg::t_cmd                cmd_in;
    stl_pkg::t_cmd                cmd_head;
    stl_pkg::t_back_stat          back_stat;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [stl_pkg::CHAR_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [stl_pkg::CHAR_W-1:0]   ram_rdata;

    // character intake and lex state
    stl_front #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fifo_full (fifo_full),
        .i_stat      (back_stat),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata)
    );

    // command queue
    stl_cmd_fifo #(
        .DEPTH (stl_pkg::CMD_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .i_pop   (pop),
        .o_head  (cmd_head),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // name buffer
    stl_ram #(
        .WIDTH (stl_pkg::CHAR_W),
        .DEPTH (MAX_NAME_LEN)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // token output
    stl_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (fifo_empty),
        .i_head  (cmd_head),
        .o_pop   (pop),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_stat  (back_stat),
        .o_out   (o_out)
    );

    // checks
    `STL_ASSERT_IMP(a_no_push_full, push, !fifo_full, "command pushed into full queue")
    `STL_ASSERT_IMP(a_no_pop_empty, pop, !fifo_empty, "command popped from empty queue")
    `STL_ASSERT_IMP(a_intake_held, back_stat.name_active, !i_in.ready, "input open during name readout")
    `STL_ASSERT_IMP(a_runs_are_names, o_out.valid && !o_out.last, o_out.token_kind == stl_pkg::TK_NAME, "multi-result run that is not a name")

endmodule

// ===== test/script_token_lexer_test_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_test_pkg
// input transaction codes shared by the stimulus and the checker
// ----------------------------------------------------------------------------
package script_token_lexer_test_pkg;

    // kind field of an input transaction
    localparam logic ITEM_CHAR = 1'b0;
    localparam logic ITEM_END  = 1'b1;

endpackage

// ===== test/script_token_lexer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_checker
// watches the character and token channels, runs its own tokenizer on every
// accepted character transaction and compares each accepted token result,
// field by field, with the oldest predicted one
// ----------------------------------------------------------------------------
module script_token_lexer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    stl_in_if    i_chars,
    stl_out_if   i_tokens,
    output int   o_mismatch_count,
    output int   o_pending_count
);
    import stl_pkg::*;
    import script_token_lexer_test_pkg::*;

    localparam int NAME_DEPTH       = MAX_NAME_LEN_DEF;
    localparam int SHOWN_MISMATCHES = 10;

    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_COMMENT,
        LEX_NUMBER,
        LEX_NAME
    } t_lex_mode;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]         frac;
        logic [CHAR_W-1:0]         ch;
        logic                      sat;
        logic                      last;
    } t_token;

    t_token    expected_tokens[$];
    t_lex_mode mode;
    logic      negative;
    logic [31:0] magnitude;
    logic [1:0]  dots;
    logic [4:0]  frac_digits;
    logic [7:0]  name_buf [NAME_DEPTH];
    logic [5:0]  name_len;
    logic        sat_flag;
    int          mismatches = 0;

    function automatic void push_token(input logic [KIND_W-1:0] kind,
                                       input logic [31:0] value,
                                       input logic [4:0] frac,
                                       input logic [7:0] ch,
                                       input logic sat,
                                       input logic last);
        t_token t;
        t.kind  = kind;
        t.value = value;
        t.frac  = frac;
        t.ch    = ch;
        t.sat   = sat;
        t.last  = last;
        expected_tokens.push_back(t);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // one digit or dot of a number; a second dot freezes the value
    function automatic void take_number_char(input logic [7:0] c);
        logic [63:0] limit;
        logic [63:0] nxt;
        if (c == ".") begin
            if (dots < 2'd2) dots = dots + 2'd1;
            return;
        end
        if (dots >= 2'd2) return;
        limit = negative ? 64'd2147483648 : 64'd2147483647;
        nxt = 64'(magnitude) * 64'd10 + (64'(c) - 64'd48);
        if (dots == 2'd0) begin
            if (nxt > limit) begin
                magnitude = limit[31:0];
                sat_flag = 1'b1;
            end else begin
                magnitude = nxt[31:0];
            end
        end else if (nxt > limit || frac_digits >= 5'd31) begin
            sat_flag = 1'b1;
        end else begin
            magnitude = nxt[31:0];
            frac_digits = frac_digits + 5'd1;
        end
    endfunction

    function automatic void take_name_char(input logic [7:0] c);
        if (name_len < NAME_DEPTH) begin
            name_buf[name_len] = c;
            name_len = name_len + 6'd1;
        end else begin
            sat_flag = 1'b1;
        end
    endfunction

    function automatic void finish_number();
        logic [31:0] v;
        v = negative ? 32'd0 - magnitude : magnitude;
        if (dots != 2'd0) push_token(TK_DECIMAL, v, frac_digits, 8'd0, sat_flag, 1'b1);
        else push_token(TK_INTEGER, v, 5'd0, 8'd0, sat_flag, 1'b1);
    endfunction

    // case-blind keyword match; a truncated name never matches
    function automatic logic keyword_is(input string kw);
        if (sat_flag || name_len != kw.len()) return 1'b0;
        for (int i = 0; i < kw.len(); i++)
            if (upcase(name_buf[i]) != kw[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void finish_name();
        if (keyword_is("IF")) push_token(TK_IF, 0, 0, 0, 0, 1);
        else if (keyword_is("SET")) push_token(TK_SET, 0, 0, 0, 0, 1);
        else if (keyword_is("DEFINE")) push_token(TK_DEFINE, 0, 0, 0, 0, 1);
        else if (keyword_is("BRIGHTER")) push_token(TK_BRIGHTER, 0, 0, 0, 0, 1);
        else if (keyword_is("MAG")) push_token(TK_MAG, 0, 0, 0, 0, 1);
        else begin
            for (int i = 0; i < name_len; i++)
                push_token(TK_NAME, 0, 0, name_buf[i], sat_flag, (i + 1) == name_len);
        end
    endfunction

    // a character seen between tokens
    function automatic void start_char(input logic [7:0] c);
        if (is_space(c)) return;
        if (c == "#") begin
            mode = LEX_COMMENT;
        end else if (is_digit(c) || c == "-" || c == "+" || c == ".") begin
            mode = LEX_NUMBER;
            negative = (c == "-");
            magnitude = 32'd0;
            dots = 2'd0;
            frac_digits = 5'd0;
            sat_flag = 1'b0;
            if (c != "-" && c != "+") take_number_char(c);
        end else if (is_alpha(c)) begin
            mode = LEX_NAME;
            name_len = 6'd0;
            sat_flag = 1'b0;
            take_name_char(c);
        end else if (c == "(") push_token(TK_LPAREN, 0, 0, 0, 0, 1);
        else if (c == ")") push_token(TK_RPAREN, 0, 0, 0, 0, 1);
        else if (c == "[") push_token(TK_LBRACK, 0, 0, 0, 0, 1);
        else if (c == "]") push_token(TK_RBRACK, 0, 0, 0, 0, 1);
        else push_token(TK_INVALID, 0, 0, 0, 0, 1);
    endfunction

    function automatic void lex_item(input logic kind, input logic [7:0] c);
        if (kind == ITEM_END) begin
            if (mode == LEX_NUMBER) finish_number();
            else if (mode == LEX_NAME) finish_name();
            mode = LEX_IDLE;
            push_token(TK_EOF, 0, 0, 0, 0, 1);
            return;
        end
        case (mode)
            LEX_COMMENT: begin
                if (c == 8'h0A) mode = LEX_IDLE;
                return;
            end
            LEX_NUMBER: begin
                if (is_digit(c) || c == ".") begin
                    take_number_char(c);
                    return;
                end
                finish_number();
                mode = LEX_IDLE;
            end
            LEX_NAME: begin
                if (is_alpha(c) || is_digit(c) || c == "+" || c == "_" || c == "-") begin
                    take_name_char(c);
                    return;
                end
                finish_name();
                mode = LEX_IDLE;
            end
            default: mode = LEX_IDLE;
        endcase
        // the character that ended a token is lexed afresh
        start_char(c);
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin : watch_channels
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            mode = LEX_IDLE;
            negative = 1'b0;
            magnitude = 32'd0;
            dots = 2'd0;
            frac_digits = 5'd0;
            name_len = 6'd0;
            sat_flag = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_chars.valid && i_chars.ready) lex_item(i_chars.kind, i_chars.char_code);
            if (i_tokens.valid && i_tokens.ready) begin
                got.kind  = i_tokens.token_kind;
                got.value = i_tokens.number_value;
                got.frac  = i_tokens.fraction_digits;
                got.ch    = i_tokens.name_char;
                got.sat   = i_tokens.saturated;
                got.last  = i_tokens.last;
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display("%0t: unexpected token kind %0d value %0d frac %0d char %02h",
                                 $realtime, got.kind, got.value, got.frac, got.ch);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MISMATCHES) begin
                            $display("%0t: expected/actual kind %0d/%0d value %0d/%0d",
                                     $realtime, want.kind, got.kind,
                                     want.value, got.value);
                            $display("  frac %0d/%0d char %02h/%02h sat %0b/%0b last %0b/%0b",
                                     want.frac, got.frac, want.ch, got.ch,
                                     want.sat, got.sat, want.last, got.last);
                        end
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count <= expected_tokens.size();
    end

endmodule

// ===== test/script_token_lexer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_top_test
// feeds the tokenizer a short directed character stream and then a long
// stream of random, mostly well-formed tokens with random gaps on both
// channels and one long output hold-off; a separate checker predicts and
// compares every token result
// ----------------------------------------------------------------------------
module script_token_lexer_top_test;
    import stl_pkg::*;
    import script_token_lexer_test_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 300;
    localparam int MAX_GAP      = 6;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic       kind;
        logic [7:0] code;
    } t_char_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    t_char_item char_stream[$];
    int         mismatch_count;
    int         pending_count;
    int         idle_cycles = 0;

    string keywords[5]    = '{"if", "set", "define", "brighter", "mag"};
    string big_numbers[5] = '{"2147483647", "2147483648", "2147483649", "99999999999", "0"};
    string letters        = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string name_chars     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+_-";
    string spaces         = " \t\n\013\014\r";
    string brackets       = "()[]";

    stl_in_if  char_if ();
    stl_out_if token_if ();

    script_token_lexer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (token_if)
    );

    script_token_lexer_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_chars          (char_if),
        .i_tokens         (token_if),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_char(input logic kind, input logic [7:0] code);
        t_char_item item;
        item.kind = kind;
        item.code = code;
        char_stream.push_back(item);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(ITEM_CHAR, s[i]);
    endfunction

    function automatic void add_digits(input int count);
        for (int i = 0; i < count; i++) add_char(ITEM_CHAR, "0" + $urandom_range(0, 9));
    endfunction

    function automatic void add_sign();
        case ($urandom_range(0, 2))
            1: add_char(ITEM_CHAR, "-");
            2: add_char(ITEM_CHAR, "+");
            default: ;
        endcase
    endfunction

    // a token may also run straight into the next one
    function automatic void add_separator();
        case ($urandom_range(0, 3))
            1, 2: add_char(ITEM_CHAR, spaces[$urandom_range(0, 5)]);
            3: add_char(ITEM_CHAR, brackets[$urandom_range(0, 3)]);
            default: ;
        endcase
    endfunction

    function automatic void add_random_token();
        string s;
        logic [7:0] c;
        int len;
        case ($urandom_range(0, 11))
            // keyword in random case
            0: begin
                s = keywords[$urandom_range(0, 4)];
                for (int i = 0; i < s.len(); i++) begin
                    c = s[i];
                    if ($urandom_range(0, 1)) c = c ^ 8'h20;
                    add_char(ITEM_CHAR, c);
                end
                add_separator();
            end
            // name, now and then longer than the buffer
            1, 2: begin
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
                add_char(ITEM_CHAR, letters[$urandom_range(0, 51)]);
                for (int i = 1; i < len; i++) add_char(ITEM_CHAR, name_chars[$urandom_range(0, 64)]);
                add_separator();
            end
            // integer, with values at and past the saturation limit
            3, 4: begin
                add_sign();
                if ($urandom_range(0, 3) == 0) add_text(big_numbers[$urandom_range(0, 4)]);
                else add_digits($urandom_range(1, 10));
                add_separator();
            end
            // decimal, sometimes with long fractions or a second dot
            5: begin
                add_sign();
                add_digits($urandom_range(0, 6));
                add_char(ITEM_CHAR, ".");
                if ($urandom_range(0, 5) == 0) add_digits($urandom_range(28, 34));
                else add_digits($urandom_range(0, 5));
                if ($urandom_range(0, 3) == 0) begin
                    add_char(ITEM_CHAR, ".");
                    add_digits($urandom_range(0, 3));
                end
                add_separator();
            end
            6: add_char(ITEM_CHAR, brackets[$urandom_range(0, 3)]);
            // comment with arbitrary bytes up to the newline
            7: begin
                add_char(ITEM_CHAR, "#");
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    c = $urandom_range(0, 255);
                    if (c == 8'h0A) c = 8'hFF;
                    add_char(ITEM_CHAR, c);
                end
                add_char(ITEM_CHAR, 8'h0A);
            end
            8: add_char(ITEM_CHAR, spaces[$urandom_range(0, 5)]);
            9: add_char(ITEM_CHAR, $urandom_range(0, 255));
            10: begin
                if ($urandom_range(0, 1)) add_char(ITEM_END, $urandom_range(0, 255));
                else add_char(ITEM_CHAR, $urandom_range(128, 255));
            end
            default: add_char(ITEM_CHAR, $urandom_range(0, 255));
        endcase
    endfunction

    // stimulus, drain and verdict
    initial begin
        int gap;
        int target;
        bit steady;
        t_char_item item;
        i_rst_n <= 1'b0;
        char_if.valid <= 1'b0;
        char_if.kind <= ITEM_CHAR;
        char_if.char_code <= 8'd0;

        // directed: byte extremes, brackets, comment, lone sign and dot,
        // sign ending a number, second dot, keyword, repeated end of input
        add_char(ITEM_CHAR, 8'h00);
        add_char(ITEM_CHAR, 8'hFF);
        add_text("()[]#z");
        add_char(ITEM_CHAR, 8'h0A);
        add_text("-+. 1.5.7if");
        add_char(ITEM_CHAR, 8'h09);
        add_char(ITEM_END, 8'h00);
        add_char(ITEM_END, 8'hFF);

        target = char_stream.size() + RANDOM_ITEMS;
        while (char_stream.size() < target) add_random_token();
        add_char(ITEM_END, 8'h00);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        steady = 1'b0;
        foreach (char_stream[n]) begin
            item = char_stream[n];
            if ($urandom_range(0, 29) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                char_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            char_if.valid <= 1'b1;
            char_if.kind <= item.kind;
            char_if.char_code <= item.code;
            do @(posedge i_clk); while (!char_if.ready);
        end
        char_if.valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // token receiver with random stalls and one long hold-off
    initial begin
        int stall;
        int taken;
        bit steady;
        token_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        taken = 0;
        steady = 1'b0;
        forever begin
            if ($urandom_range(0, 29) == 0) steady = !steady;
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                token_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            token_if.ready <= 1'b1;
            do @(posedge i_clk); while (!token_if.valid);
            taken++;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((char_if.valid && char_if.ready) || (token_if.valid && token_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/stl_pkg.sv
rtl/core/stl_ifs.sv
rtl/core/stl_ram.sv
rtl/core/stl_cmd_fifo.sv
rtl/core/stl_front.sv
rtl/core/stl_back.sv
rtl/core/script_token_lexer_top.sv
test/script_token_lexer_test_pkg.sv
test/script_token_lexer_checker.sv
test/script_token_lexer_top_test.sv
